[design/rme_pkg.sv]
// shared constants, types and functions for the rotation matrix to euler block
`default_nettype none
package rme_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned CordicStagesMax = 24;
  localparam int unsigned SqrtSteps       = 16;

  // cordic datapath widths: operands scaled by 2^16, grow by a few bits
  localparam int unsigned XyW = 38;
  localparam int unsigned ZW  = 26;

  localparam logic signed [ZW-1:0] Deg180Q16 = 26'sd11796480;
  localparam logic signed [15:0]   OutLimit  = 16'sd23040;

  typedef logic signed [15:0] q2_14_t;
  typedef logic signed [15:0] q9_7_t;
  typedef logic [14:0]        thresh_t;
  typedef logic [32:0]        sumsq_t;
  typedef logic [16:0]        root_t;

  // one cordic lane in flight
  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
    logic                  zero;
  } lane_t;

  // side data that travels next to the square-root chain
  // ny_* entries are negated at lane setup, where there is room for +32768
  typedef struct packed {
    q2_14_t x_psi;
    q2_14_t y_psi;
    q2_14_t x_phi;
    q2_14_t y_phi;
    q2_14_t ny_theta;
    q2_14_t x_sng;
    q2_14_t ny_sng;
  } side_t;

  // arctangent table in degrees scaled by 2^16
  function automatic logic [ZW-1:0] atan_deg(input logic [4:0] idx);
    logic [ZW-1:0] r;
    case (idx)
      5'd0:  r = 26'd2949120;
      5'd1:  r = 26'd1740967;
      5'd2:  r = 26'd919879;
      5'd3:  r = 26'd466945;
      5'd4:  r = 26'd234379;
      5'd5:  r = 26'd117304;
      5'd6:  r = 26'd58666;
      5'd7:  r = 26'd29335;
      5'd8:  r = 26'd14668;
      5'd9:  r = 26'd7334;
      5'd10: r = 26'd3667;
      5'd11: r = 26'd1833;
      5'd12: r = 26'd917;
      5'd13: r = 26'd458;
      5'd14: r = 26'd229;
      5'd15: r = 26'd115;
      5'd16: r = 26'd57;
      5'd17: r = 26'd29;
      5'd18: r = 26'd14;
      5'd19: r = 26'd7;
      5'd20: r = 26'd4;
      5'd21: r = 26'd2;
      5'd22: r = 26'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // prepare a lane: scale, fold left half plane into the right one
  function automatic lane_t lane_init(input logic signed [17:0] y,
                                      input logic signed [17:0] x);
    lane_t l;
    logic signed [XyW-1:0] xs;
    logic signed [XyW-1:0] ys;
    xs = {{(XyW-34){x[17]}}, x, 16'd0};
    ys = {{(XyW-34){y[17]}}, y, 16'd0};
    l.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      l.x = -xs;
      l.y = -ys;
      l.z = (y >= 0) ? Deg180Q16 : -Deg180Q16;
    end else begin
      l.x = xs;
      l.y = ys;
      l.z = '0;
    end
    return l;
  endfunction

  // rounding and saturation of a finished angle into q9.7
  function automatic q9_7_t to_q9_7(input lane_t l);
    logic signed [ZW-1:0] zr;
    logic signed [ZW-10:0] q;
    zr = l.z + ZW'(256);
    q  = zr[ZW-1:9];
    if (l.zero) return '0;
    if (q > OutLimit) return OutLimit;
    if (q < -OutLimit) return -OutLimit;
    return q[15:0];
  endfunction

endpackage
`default_nettype wire

[design/rme_if.sv]
// valid/ready channel interfaces for matrix input and angle output
`default_nettype none
interface rme_in_if;
  logic          valid;
  logic          ready;
  rme_pkg::q2_14_t col0_row0;
  rme_pkg::q2_14_t col1_row0;
  rme_pkg::q2_14_t col1_row1;
  rme_pkg::q2_14_t col1_row2;
  rme_pkg::q2_14_t col2_row0;
  rme_pkg::q2_14_t col2_row1;
  rme_pkg::q2_14_t col2_row2;
  modport source (output valid, col0_row0, col1_row0, col1_row1, col1_row2,
                  col2_row0, col2_row1, col2_row2, input ready);
  modport sink   (input valid, col0_row0, col1_row0, col1_row1, col1_row2,
                  col2_row0, col2_row1, col2_row2, output ready);
endinterface

interface rme_out_if;
  logic          valid;
  logic          ready;
  rme_pkg::q9_7_t roll_deg;
  rme_pkg::q9_7_t pitch_deg;
  rme_pkg::q9_7_t yaw_deg;
  logic          is_singular;
  modport source (output valid, roll_deg, pitch_deg, yaw_deg, is_singular, input ready);
  modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, is_singular, output ready);
endinterface
`default_nettype wire

[design/rme_sqrt_cell.sv]
// one restoring square-root step: resolves one root bit per cell
`default_nettype none
module rme_sqrt_cell #(
  parameter int unsigned Step = 0
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire rme_pkg::sumsq_t rem_i,
  input  wire rme_pkg::root_t  root_i,
  input  wire rme_pkg::side_t  side_i,
  output rme_pkg::sumsq_t     rem_o,
  output rme_pkg::root_t      root_o,
  output rme_pkg::side_t      side_o
);
  import rme_pkg::*;

  localparam int unsigned Sh = 2 * (SqrtSteps - 1 - Step);

  logic [34:0] trial;
  logic [34:0] bitv;
  sumsq_t      rem_d;
  root_t       root_d;
  sumsq_t      rem_q;
  root_t       root_q;
  side_t       side_q;

  // root_i holds the upper root bits in place: test remainder against 2*root*b + b*b
  always_comb begin
    bitv   = 35'd1 << Sh;
    trial  = ({18'd0, root_i} << (SqrtSteps - Step)) + bitv;
    if ({2'd0, rem_i} >= trial) begin
      rem_d  = rem_i - trial[32:0];
      root_d = root_i | (17'd1 << (SqrtSteps - 1 - Step));
    end else begin
      rem_d  = rem_i;
      root_d = root_i;
    end
  end

  // payload stage, moves with the pipeline enable
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;
endmodule
`default_nettype wire

[design/rme_cordic_cell.sv]
// one cordic vectoring micro-rotation on three lanes
`default_nettype none
module rme_cordic_cell #(
  parameter int unsigned Step = 0
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire rme_pkg::lane_t lane_i [3],
  output rme_pkg::lane_t     lane_o [3]
);
  import rme_pkg::*;

  lane_t lane_d [3];
  lane_t lane_q [3];
  logic [ZW-1:0] ang;

  assign ang = atan_deg(5'(Step));

  // rotate toward the x axis, accumulate angle
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_d[k].zero = lane_i[k].zero;
      if (lane_i[k].y < 0) begin
        lane_d[k].x = lane_i[k].x - (lane_i[k].y >>> Step);
        lane_d[k].y = lane_i[k].y + (lane_i[k].x >>> Step);
        lane_d[k].z = lane_i[k].z - $signed(ang);
      end else begin
        lane_d[k].x = lane_i[k].x + (lane_i[k].y >>> Step);
        lane_d[k].y = lane_i[k].y - (lane_i[k].x >>> Step);
        lane_d[k].z = lane_i[k].z + $signed(ang);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) lane_q <= lane_d;
  end

  assign lane_o = lane_q;
endmodule
`default_nettype wire

[design/rotation_matrix_to_euler.sv]
// top level: square-root chain, then cordic chain, then output register
// registers: input, 16 sqrt cells, lane setup, CORDIC_STAGES cordic cells, output
// throughput: one transaction per cycle; the whole chain stalls when the
// output register is full and not taken
// reset: rst_ni clears all valid flags and sets singular_threshold to 1;
// datapath registers are not reset
`default_nettype none
module rotation_matrix_to_euler #(
  parameter int unsigned CORDIC_STAGES = rme_pkg::CordicStagesDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire rme_pkg::thresh_t cfg_wdata_i,
  rme_in_if.sink               in_i,
  rme_out_if.source            out_o
);
  import rme_pkg::*;

  localparam int unsigned Depth = SqrtSteps + 2 + CORDIC_STAGES + 1;

  thresh_t thr_q;
  logic [Depth-1:0] vld_q;
  logic en;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= 15'd1;
    else if (cfg_we_i) thr_q <= cfg_wdata_i;
  end

  // whole chain advances unless the final output is stuck
  assign en         = !(vld_q[Depth-1] && !out_o.ready);
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], in_i.valid};
  end

  // squares of the first row entries
  logic signed [31:0] sq00;
  logic signed [31:0] sq10;
  assign sq00 = in_i.col0_row0 * in_i.col0_row0;
  assign sq10 = in_i.col1_row0 * in_i.col1_row0;

  // input register: sum of squares and side data
  sumsq_t sumsq_q;
  side_t  side0_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sumsq_q <= {1'b0, sq00} + {1'b0, sq10};
      side0_q <= '{x_psi: in_i.col2_row2, y_psi: in_i.col2_row1,
                   x_phi: in_i.col0_row0, y_phi: in_i.col1_row0,
                   ny_theta: in_i.col2_row0,
                   x_sng: in_i.col1_row1, ny_sng: in_i.col1_row2};
    end
  end

  // square-root chain
  sumsq_t rem_w  [SqrtSteps+1];
  root_t  root_w [SqrtSteps+1];
  side_t  side_w [SqrtSteps+1];
  assign rem_w[0]  = sumsq_q;
  assign root_w[0] = '0;
  assign side_w[0] = side0_q;
  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    rme_sqrt_cell #(.Step(g)) u_cell (
      .clk_i, .en_i(en),
      .rem_i(rem_w[g]), .root_i(root_w[g]), .side_i(side_w[g]),
      .rem_o(rem_w[g+1]), .root_o(root_w[g+1]), .side_o(side_w[g+1])
    );
  end

  // branch select and lane setup
  lane_t lane_w [CORDIC_STAGES+1][3];
  logic  sing_sr_q [CORDIC_STAGES+1];
  logic  sing;
  side_t sd;
  logic signed [17:0] y_theta;
  logic signed [17:0] y_sng;
  assign sd      = side_w[SqrtSteps];
  assign sing    = {1'b0, root_w[SqrtSteps]} < {3'd0, thr_q};
  assign y_theta = -18'(sd.ny_theta);
  assign y_sng   = -18'(sd.ny_sng);

  // singular case takes psi from col1_row1 and col1_row2
  always_ff @(posedge clk_i) begin
    if (en) begin
      lane_w[0][0] <= sing ? lane_init(y_sng, 18'(sd.x_sng))
                           : lane_init(18'(sd.y_psi), 18'(sd.x_psi));
      lane_w[0][1] <= lane_init(y_theta, $signed({1'b0, root_w[SqrtSteps]}));
      lane_w[0][2] <= lane_init(18'(sd.y_phi), 18'(sd.x_phi));
      sing_sr_q[0] <= sing;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    rme_cordic_cell #(.Step(g)) u_cell (
      .clk_i, .en_i(en), .lane_i(lane_w[g]), .lane_o(lane_w[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) sing_sr_q[g+1] <= sing_sr_q[g];
    end
  end

  // output register
  q9_7_t roll_q, pitch_q, yaw_q;
  logic  sing_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= to_q9_7(lane_w[CORDIC_STAGES][0]);
      pitch_q <= to_q9_7(lane_w[CORDIC_STAGES][1]);
      yaw_q   <= sing_sr_q[CORDIC_STAGES] ? '0 : to_q9_7(lane_w[CORDIC_STAGES][2]);
      sing_q  <= sing_sr_q[CORDIC_STAGES];
    end
  end

  assign out_o.valid       = vld_q[Depth-1];
  assign out_o.roll_deg    = roll_q;
  assign out_o.pitch_deg   = pitch_q;
  assign out_o.yaw_deg     = yaw_q;
  assign out_o.is_singular = sing_q;
endmodule
`default_nettype wire

[design/rme_checker.sv]
// port-level checker bound to the top level
`default_nettype none
module rme_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic in_ready_i,
  input wire logic [15:0] yaw_i,
  input wire logic sing_i
);
  // yaw is zero on singular results
  a_yaw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && sing_i |-> yaw_i == 16'd0) else $error("yaw not zero");
  // input stalls only when output is blocked
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i) else $error("spurious stall");
  // held result stays
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(yaw_i))
    else $error("result dropped");
endmodule

bind rotation_matrix_to_euler rme_checker u_chk (
  .clk_i, .rst_ni, .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .in_ready_i(in_i.ready), .yaw_i(out_o.yaw_deg), .sing_i(out_o.is_singular));
`default_nettype wire

[tb/rotation_matrix_to_euler_tb.sv]
// testbench for the rotation matrix to euler angle block
`default_nettype none
module rotation_matrix_to_euler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rme_pkg::*;

  localparam int Stages    = 16;
  localparam int Latency   = 19 + Stages;
  localparam int StallMax  = 2000;

  // matrix entries of one transaction
  typedef struct {
    q2_14_t c00, c10, c11, c12, c20, c21, c22;
  } matrix_t;

  // angles of one result
  typedef struct {
    q9_7_t roll, pitch, yaw;
    logic  singular;
  } euler_t;

  logic    clk_i;
  logic    rst_ni;
  logic    cfg_we_i;
  thresh_t cfg_wdata_i;

  rme_in_if  in_ch ();
  rme_out_if out_ch ();

  rotation_matrix_to_euler #(.CORDIC_STAGES(Stages)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch.sink),
    .out_o       (out_ch.source)
  );

  thresh_t  threshold;
  euler_t   pending_angles[$];
  int       mismatches;
  int       results_seen;
  int       singular_seen;
  int       idle_cycles;
  bit       gaps_on;

  // arctangent table in degrees scaled by 2^16
  const longint AtanTab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0};

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // vectoring cordic angle in q9.7 degrees
  function automatic q9_7_t atan2_q97(longint y, longint x);
    longint z, xs, ys, q;
    z = 0;
    if (x == 0 && y == 0) return '0;
    x = x * 65536;
    y = y * 65536;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Stages; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - AtanTab[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + AtanTab[i];
      end
    end
    q = (z + 256) >>> 9;
    if (q > 23040) q = 23040;
    if (q < -23040) q = -23040;
    return q9_7_t'(q);
  endfunction

  // integer square root, floor
  function automatic longint floor_sqrt(longint n);
    longint r;
    r = 0;
    for (int b = 16; b >= 0; b--)
      if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= n) r = r + (64'sd1 << b);
    return r;
  endfunction

  // expected euler angles for one matrix
  function automatic euler_t matrix_to_euler(matrix_t m);
    euler_t e;
    longint sy;
    sy = floor_sqrt(longint'(m.c00) * m.c00 + longint'(m.c10) * m.c10);
    e.singular = (sy < longint'(threshold));
    e.pitch = atan2_q97(-longint'(m.c20), sy);
    if (!e.singular) begin
      e.roll = atan2_q97(m.c21, m.c22);
      e.yaw  = atan2_q97(m.c10, m.c00);
    end else begin
      e.roll = atan2_q97(-longint'(m.c12), m.c11);
      e.yaw  = '0;
    end
    return e;
  endfunction

  // sink ready with random stall bursts
  initial begin
    int burst;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (gaps_on && burst == 0 && $urandom_range(0, 5) == 0)
        burst = $urandom_range(1, 3);
      if (burst > 0) begin
        out_ch.ready <= 1'b0;
        burst--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    euler_t exp_e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.is_singular) singular_seen++;
      if (pending_angles.size() == 0) begin
        $display("%0t unexpected result roll=%0d pitch=%0d yaw=%0d sing=%0b", $time,
                 out_ch.roll_deg, out_ch.pitch_deg, out_ch.yaw_deg, out_ch.is_singular);
        mismatches++;
      end else begin
        exp_e = pending_angles.pop_front();
        if (out_ch.roll_deg !== exp_e.roll || out_ch.pitch_deg !== exp_e.pitch ||
            out_ch.yaw_deg !== exp_e.yaw || out_ch.is_singular !== exp_e.singular) begin
          $display("%0t mismatch exp roll=%0d pitch=%0d yaw=%0d sing=%0b", $time,
                   exp_e.roll, exp_e.pitch, exp_e.yaw, exp_e.singular);
          $display("%0t          act roll=%0d pitch=%0d yaw=%0d sing=%0b", $time,
                   out_ch.roll_deg, out_ch.pitch_deg, out_ch.yaw_deg, out_ch.is_singular);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallMax) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // send one matrix, with an optional random gap before it
  task automatic send_matrix(matrix_t m);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.col0_row0 <= m.c00;
    in_ch.col1_row0 <= m.c10;
    in_ch.col1_row1 <= m.c11;
    in_ch.col1_row2 <= m.c12;
    in_ch.col2_row0 <= m.c20;
    in_ch.col2_row1 <= m.c21;
    in_ch.col2_row2 <= m.c22;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_angles.push_back(matrix_to_euler(m));
  endtask

  // wait for all results, then let the pipeline settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_threshold(thresh_t v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    threshold = v;
  endtask

  function automatic q2_14_t rand_entry();
    case ($urandom_range(0, 9))
      0: return q2_14_t'($urandom);
      1: return 16'sd16384;
      2: return -16'sd16384;
      3: return q2_14_t'($urandom_range(0, 8)) - 16'sd4;
      default: return q2_14_t'($urandom_range(0, 32768)) - 16'sd16384;
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    m.c00 = rand_entry(); m.c10 = rand_entry(); m.c11 = rand_entry();
    m.c12 = rand_entry(); m.c20 = rand_entry(); m.c21 = rand_entry();
    m.c22 = rand_entry();
    // near gimbal lock now and then
    if ($urandom_range(0, 4) == 0) begin
      m.c00 = q2_14_t'($urandom_range(0, 64)) - 16'sd32;
      m.c10 = q2_14_t'($urandom_range(0, 64)) - 16'sd32;
    end
    return m;
  endfunction

  // extremes, zero vectors, half-plane folds and singular cases
  task automatic test_directed();
    matrix_t m;
    q2_14_t  vals[6] = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd1, -16'sd1, 16'sh7fff};
    m = '{0, 0, 0, 0, 0, 0, 0};
    send_matrix(m);
    for (int i = 0; i < 6; i++) begin
      m = '{vals[i], vals[(i+1)%6], vals[(i+2)%6], vals[(i+3)%6],
            vals[(i+4)%6], vals[(i+5)%6], vals[i]};
      send_matrix(m);
    end
    m = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    send_matrix(m);
    m = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    send_matrix(m);
    // negative x with zero y, and gimbal lock pitch up and down
    m = '{-16'sd16384, 0, -16'sd16384, 0, 0, 0, -16'sd16384};
    send_matrix(m);
    m = '{0, 0, 16'sd16384, -16'sd16384, -16'sd16384, 0, 0};
    send_matrix(m);
    m = '{0, 0, -16'sd5000, 16'sd7000, 16'sd16384, 0, 0};
    send_matrix(m);
    m = '{16'sd11585, 16'sd11585, 16'sd11585, -16'sd11585, 0, 16'sd11585, 16'sd11585};
    send_matrix(m);
  endtask

  // random matrices across thresholds, extremes included
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_matrix(rand_matrix());
  endtask

  initial begin
    thresh_t thr_list[5] = '{15'd0, 15'd16, 15'd4096, 15'd16384, 15'h7fff};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.col0_row0 = '0; in_ch.col1_row0 = '0; in_ch.col1_row1 = '0;
    in_ch.col1_row2 = '0; in_ch.col2_row0 = '0; in_ch.col2_row1 = '0;
    in_ch.col2_row2 = '0;
    threshold = 15'd1;
    mismatches = 0; results_seen = 0; singular_seen = 0; idle_cycles = 0;
    gaps_on = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    drain();
    foreach (thr_list[k]) begin
      write_threshold(thr_list[k]);
      test_directed();
      test_random(65);
      drain();
    end
    write_threshold(15'd8192);
    gaps_on = 1'b0;
    test_random(100);
    drain();

    $display("checked %0d results, %0d singular, thresholds 0 through 32767", results_seen,
             singular_seen);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
